// ----- design/ssc_pkg.sv -----
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int NEEDLE_MAX   = 16;
    localparam int HAYSTACK_MAX = 65536;

    localparam int WIN_DEPTH  = NEEDLE_MAX - 1;
    localparam int LEN_W      = 5;
    localparam int NIDX_W     = $clog2(NEEDLE_MAX);
    localparam int SEEN_W     = $clog2(HAYSTACK_MAX) + 1;
    localparam int POS_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_SEARCH   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    typedef logic [7:0] t_byte;

endpackage

// ----- design/substring_search_case_fold.sv -----
`timescale 1ns / 1ps

// Streaming substring search with optional ASCII case folding.
// Configuration: write needle bytes 0-7 (index 0), 8-15 (index 1), needle
// length (index 2) and the case fold bit (index 3) on the cfg channel while
// no items are in flight; o_cfg_ready is always high.
// Input: one haystack byte per item on the s-side, tlast on the final byte
// of a haystack. Output: one result item per input item on the m-side,
// status in tdata[2:0] and match offset in tdata[18:3].
// Throughput is one byte per cycle unless the receiver stalls: the 16-byte
// window compare and status select sit between the window/counter registers
// and the single output register; o_m_tvalid rises the cycle after accept.
// When the receiver stalls, the output register holds its item and a new
// input item is taken in the same cycle the held one leaves.
// Reset clears the configuration, the byte window, the byte counter and the
// match state, and empties the output register. After the item marked last
// the search state returns to its reset value; configuration is kept.
module substring_search_case_fold (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ssc_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [7:0] data_byte
    input  logic                           i_s_tlast,   // last_byte
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ssc_pkg::OUT_DATA_W-1:0] o_m_tdata    // [2:0] status, [18:3] match_position
);
    import ssc_pkg::*;

    logic [CFG_DATA_W-1:0] r_needle_low;
    logic [CFG_DATA_W-1:0] r_needle_high;
    logic [LEN_W-1:0]      r_needle_len;
    logic                  r_case_fold;

    t_byte              r_win [WIN_DEPTH];
    logic [SEEN_W-1:0]  r_seen;
    logic               r_match_taken;
    logic [POS_W-1:0]   r_found_offset;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [POS_W-1:0]    r_out_pos;

    logic                in_accept;
    logic [LEN_W-1:0]    len;
    logic [2*CFG_DATA_W-1:0] needle;
    t_byte               hay [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] byte_ok;
    logic                hit;
    logic [STATUS_W-1:0] n_status;
    logic [POS_W-1:0]    n_pos;
    logic [POS_W-1:0]    match_pos;

    function automatic t_byte swap_case(t_byte c);
        t_byte r;
        r = c;
        if (c > 8'd96 && c < 8'd123) begin
            r = c - 8'd32;
        end else if (c > 8'd64 && c < 8'd91) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign in_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {(OUT_DATA_W - STATUS_W - POS_W)'(0), r_out_pos, r_out_status};

    assign len    = (r_needle_len > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX) : r_needle_len;
    assign needle = {r_needle_high, r_needle_low};

    // newest byte first: the incoming byte, then the window
    always_comb begin
        hay[0] = i_s_tdata[7:0];
        for (int k = 1; k < NEEDLE_MAX; k++) begin
            hay[k] = r_win[k-1];
        end
    end

    // window place k lines up with needle byte len-1-k
    always_comb begin
        logic [NIDX_W-1:0] idx;
        t_byte             nb;
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            idx = NIDX_W'(len - LEN_W'(1) - LEN_W'(k));
            nb  = needle[8*idx +: 8];
            byte_ok[k] = (LEN_W'(k) >= len) || (hay[k] == nb)
                         || (r_case_fold && swap_case(hay[k]) == nb);
        end
    end

    assign hit = (len != '0)
                 && ((SEEN_W+1)'(r_seen) + (SEEN_W+1)'(1) >= (SEEN_W+1)'(len))
                 && (&byte_ok);
    assign match_pos = POS_W'(r_seen + SEEN_W'(1) - SEEN_W'(len));

    always_comb begin
        n_status = ST_SEARCH;
        n_pos    = '0;
        priority if (r_match_taken) begin
            n_status = ST_IGNORED;
            n_pos    = r_found_offset;
        end else if (r_seen >= SEEN_W'(HAYSTACK_MAX)) begin
            n_status = ST_OVERFLOW;
        end else if (hit) begin
            n_status = ST_MATCH;
            n_pos    = match_pos;
        end else if (i_s_tlast) begin
            n_status = ST_NO_MATCH;
        end else begin
            n_status = ST_SEARCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_needle_len  <= '0;
            r_case_fold   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_NEEDLE_LOW:  r_needle_low  <= i_cfg_data;
                REG_NEEDLE_HIGH: r_needle_high <= i_cfg_data;
                REG_NEEDLE_LEN:  r_needle_len  <= i_cfg_data[LEN_W-1:0];
                REG_CASE_FOLD:   r_case_fold   <= i_cfg_data[0];
                default:         r_case_fold   <= r_case_fold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                r_win[k] <= '0;
            end
            r_seen         <= '0;
            r_match_taken  <= 1'b0;
            r_found_offset <= '0;
        end else if (in_accept) begin
            if (i_s_tlast) begin
                // end of haystack: restart the search
                for (int k = 0; k < WIN_DEPTH; k++) begin
                    r_win[k] <= '0;
                end
                r_seen         <= '0;
                r_match_taken  <= 1'b0;
                r_found_offset <= '0;
            end else begin
                for (int k = 0; k < WIN_DEPTH; k++) begin
                    r_win[k] <= hay[k];
                end
                if (r_seen < SEEN_W'(HAYSTACK_MAX)) begin
                    r_seen <= r_seen + SEEN_W'(1);
                end
                if (n_status == ST_MATCH) begin
                    r_match_taken  <= 1'b1;
                    r_found_offset <= match_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_status <= n_status;
            r_out_pos    <= n_pos;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_s_tlast |=> r_seen == '0 && !r_match_taken)
        else $error("search state not cleared after last item");

    a_taken_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_taken |-> r_seen != '0)
        else $error("match taken with no bytes seen");

    a_seen_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(HAYSTACK_MAX))
        else $error("byte counter past saturation");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    a_match_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_match_taken |=> r_out_status == ST_IGNORED)
        else $error("result after a match not marked ignored");

endmodule
